>>> sv/scp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg
// Shared constants, coefficients and the side-band type of the Horner chain.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int FRAC = 59;  // internal format Q4.59

  localparam logic signed [63:0] K_PI       = 64'sh1921FB54442D1847;
  localparam logic signed [63:0] K_TWO_PI   = 64'sh3243F6A8885A308D;
  localparam logic signed [63:0] K_FOUR_PI  = 64'sh6487ED5110B4611A;
  localparam logic signed [63:0] K_HALF_PI  = 64'sh0C90FDAA22168C23;
  localparam logic signed [63:0] K_QUART_PI = 64'sh06487ED5110B4612;
  localparam logic signed [63:0] K_ONE      = 64'sd576460752303423488;

  localparam logic [13:0] K_INV_TWO_PI_Q16 = 14'd10430;

  localparam logic signed [63:0] SIN_COEF [6] = '{
    -64'sd96076792050570581, 64'sd4803839602528529,
    -64'sd114377133393536,   64'sd1588571297132,
    -64'sd14441557247,       64'sd92574085
  };
  localparam logic signed [63:0] COS_COEF [6] = '{
    -64'sd288230376151711744, 64'sd24019198012642645,
    -64'sd800639933754755,    64'sd14297141674192,
    -64'sd158857129713,       64'sd1203463104
  };

  localparam logic CMD_SIN = 1'b0;
  localparam logic CMD_COS = 1'b1;

  typedef struct packed {
    logic               valid;
    logic               is_sin;
    logic               neg_res;
    logic signed [63:0] x;
    logic signed [63:0] x2;
  } side_t;

endpackage

>>> sv/scp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_in_if / scp_out_if
// Valid/ready channels for the angle request and the result.
// ----------------------------------------------------------------------------
interface scp_in_if #(parameter int ANGLE_WIDTH = 32) ();
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [ANGLE_WIDTH-1:0] angle;
  modport source (output valid, cmd, angle, input ready);
  modport sink   (input valid, cmd, angle, output ready);
endinterface

interface scp_out_if #(parameter int RESULT_WIDTH = 32) ();
  logic                           valid;
  logic                           ready;
  logic signed [RESULT_WIDTH-1:0] value;
  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

>>> sv/scp_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_mac
// Four-stage Q4.59 multiply-add: addend + round(a * b), ties away from zero.
// ----------------------------------------------------------------------------
module scp_mac
  import scp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic signed [63:0] addend,
  input  side_t              side_in,
  output logic signed [63:0] res,
  output side_t              side_out
);

  side_t              side_r [4];
  logic               neg_a_r, neg_b_r, neg_c_r;
  logic [63:0]        ua_r, ub_r;
  logic [63:0]        ll_r, lh_r, hl_r, hh_r;
  logic [62:0]        mag_r;
  logic signed [63:0] add_a_r, add_b_r, add_c_r, res_r;
  logic [127:0]       sum_nxt;
  logic [63:0]        sres_nxt;

  always_comb begin
    sum_nxt = {hh_r, 64'd0} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0}
            + {64'd0, ll_r} + (128'd1 << (FRAC - 1));
    sres_nxt = neg_c_r ? (64'd0 - {1'b0, mag_r}) : {1'b0, mag_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) side_r[i].valid <= 1'b0;
    end else if (en) begin
      side_r[0] <= side_in;
      for (int i = 1; i < 4; i++) side_r[i] <= side_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitudes
      neg_a_r <= a[63] ^ b[63];
      ua_r    <= a[63] ? 64'd0 - a : a;
      ub_r    <= b[63] ? 64'd0 - b : b;
      add_a_r <= addend;
      // partial products
      neg_b_r <= neg_a_r;
      ll_r    <= ua_r[31:0]  * ub_r[31:0];
      lh_r    <= ua_r[31:0]  * ub_r[63:32];
      hl_r    <= ua_r[63:32] * ub_r[31:0];
      hh_r    <= ua_r[63:32] * ub_r[63:32];
      add_b_r <= add_a_r;
      // sum and round
      neg_c_r <= neg_b_r;
      mag_r   <= sum_nxt[FRAC+62:FRAC];
      add_c_r <= add_b_r;
      // sign and accumulate
      res_r   <= add_c_r + sres_nxt;
    end
  end

  assign res      = res_r;
  assign side_out = side_r[3];

endmodule

>>> sv/sine_cosine_polynomial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_cosine_polynomial
// Pipelined fixed-point sine/cosine by range reduction and Taylor polynomial.
// ----------------------------------------------------------------------------
// A request (cmd 0 sine, 1 cosine; angle in radians, Q8.24 at default width)
// yields one Q2.30 result saturated to +/-1.0. The block takes one request
// per cycle unless the result side stalls; each request spends 6 reduction
// stages, 8 multiply-add units of 4 stages each and 3 output stages. A
// stall on the result side freezes the whole pipeline, nothing is dropped.
module sine_cosine_polynomial
  import scp_pkg::*;
#(
  parameter int ANGLE_WIDTH  = 32,
  parameter int RESULT_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  scp_in_if.sink     in_ch,
  scp_out_if.source  out_ch
);

  localparam int ANG_FRAC = ANGLE_WIDTH - 8;
  localparam int MAG_SH   = FRAC - ANG_FRAC;
  localparam int RES_SH   = FRAC - (RESULT_WIDTH - 2);
  localparam int UM_W     = 65 - RES_SH;

  logic en;
  logic out_valid_r;
  logic signed [RESULT_WIDTH-1:0] out_value_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // reduction stages
  logic                   v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic                   cos1_r, cos2_r, cos3_r, cos4_r;
  logic                   neg1_r, neg2_r, neg3_r;
  logic [ANGLE_WIDTH-1:0] mag1_r;
  logic [5:0]             k1_r;
  logic signed [63:0]     ur2_r, r3_r, r4_r, r5_r, r6_r;

  logic [ANGLE_WIDTH-1:0]  mag_nxt;
  logic [ANGLE_WIDTH+13:0] kprod_nxt;
  logic signed [63:0]      t1, t2, s5, r6_nxt;

  always_comb begin
    mag_nxt   = in_ch.angle[ANGLE_WIDTH-1] ? ('0 - in_ch.angle) : in_ch.angle;
    kprod_nxt = mag_nxt * K_INV_TWO_PI_Q16;
    t1        = ur2_r - K_TWO_PI;
    t2        = ur2_r - K_FOUR_PI;
    s5        = r4_r + K_HALF_PI;
    if (r5_r > K_HALF_PI)       r6_nxt = K_PI - r5_r;
    else if (r5_r < -K_HALF_PI) r6_nxt = -K_PI - r5_r;
    else                        r6_nxt = r5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r} <= '0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos1_r <= (in_ch.cmd == CMD_COS);
      neg1_r <= in_ch.angle[ANGLE_WIDTH-1];
      mag1_r <= mag_nxt;
      k1_r   <= kprod_nxt[ANGLE_WIDTH+13:ANGLE_WIDTH+8];

      cos2_r <= cos1_r;
      neg2_r <= neg1_r;
      ur2_r  <= (64'(mag1_r) << MAG_SH) - (64'(k1_r) * K_TWO_PI);

      cos3_r <= cos2_r;
      neg3_r <= neg2_r;
      r3_r   <= (ur2_r > K_PI) ? ((t1 > K_PI) ? t2 : t1) : ur2_r;

      cos4_r <= cos3_r;
      r4_r   <= neg3_r ? -r3_r : r3_r;

      r5_r   <= cos4_r ? ((s5 > K_PI) ? s5 - K_TWO_PI : s5) : r4_r;

      r6_r   <= r6_nxt;
    end
  end

  // region select into the Horner chain
  side_t              chain_side [9];
  logic signed [63:0] chain_p    [9];

  always_comb begin
    chain_side[0]         = '0;
    chain_side[0].valid   = v6_r;
    chain_p[0]            = '0;
    if (r6_r > K_QUART_PI) begin
      chain_side[0].x = r6_r - K_HALF_PI;
    end else if (r6_r < -K_QUART_PI) begin
      chain_side[0].x       = -r6_r - K_HALF_PI;
      chain_side[0].neg_res = 1'b1;
    end else begin
      chain_side[0].x      = r6_r;
      chain_side[0].is_sin = 1'b1;
    end
  end

  for (genvar j = 0; j < 8; j++) begin : g_mac
    logic signed [63:0] op_a, op_b, op_add, mres;
    side_t              sd_o;

    if (j == 0) begin : g_op
      assign op_a   = chain_side[j].x;
      assign op_b   = chain_side[j].x;
      assign op_add = '0;
    end else if (j <= 5) begin : g_op
      assign op_a   = chain_side[j].x2;
      assign op_b   = chain_p[j];
      assign op_add = chain_side[j].is_sin ? SIN_COEF[5-j] : COS_COEF[5-j];
    end else if (j == 6) begin : g_op
      assign op_a   = chain_side[j].x2;
      assign op_b   = chain_p[j];
      assign op_add = K_ONE;
    end else begin : g_op
      assign op_a   = chain_p[j];
      assign op_b   = chain_side[j].is_sin ? chain_side[j].x : K_ONE;
      assign op_add = '0;
    end

    scp_mac u_mac (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .a        (op_a),
      .b        (op_b),
      .addend   (op_add),
      .side_in  (chain_side[j]),
      .res      (mres),
      .side_out (sd_o)
    );

    always_comb begin
      chain_side[j+1] = sd_o;
      chain_p[j+1]    = mres;
      if (j == 0) begin
        chain_side[j+1].x2 = mres;
        chain_p[j+1] = sd_o.is_sin ? SIN_COEF[5] : COS_COEF[5];
      end
    end
  end

  // output rounding and saturation
  logic                v_o1_r, v_o2_r;
  logic signed [63:0]  val_o1_r;
  logic                sgn_o2_r;
  logic [UM_W-1:0]     um_o2_r;
  logic [64:0]         rnd_nxt;
  logic [UM_W-1:0]     um_sat;

  always_comb begin
    rnd_nxt = {1'b0, (val_o1_r[63] ? 64'd0 - val_o1_r : val_o1_r)}
            + (65'd1 << (RES_SH - 1));
    um_sat  = (um_o2_r > (UM_W'(1) << (RESULT_WIDTH - 2)))
            ? (UM_W'(1) << (RESULT_WIDTH - 2)) : um_o2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o1_r      <= 1'b0;
      v_o2_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_o1_r      <= chain_side[8].valid;
      v_o2_r      <= v_o1_r;
      out_valid_r <= v_o2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_o1_r    <= chain_side[8].neg_res ? -chain_p[8] : chain_p[8];
      sgn_o2_r    <= val_o1_r[63];
      um_o2_r     <= rnd_nxt[64:RES_SH];
      out_value_r <= sgn_o2_r ? RESULT_WIDTH'('0 - um_sat) : RESULT_WIDTH'(um_sat);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.value = out_value_r;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pipelined sine/cosine polynomial unit.
// ----------------------------------------------------------------------------
// Requests are driven on the valid/ready input channel with random gaps.
// Each accepted request is predicted in Q4.59 fixed point and held in order.
// Every result is compared with the oldest prediction. One long hold-off on
// the result side fills the pipeline so that the input side has to stall.
module testbench;
  import scp_pkg::*;

  localparam int AW = 32;
  localparam int RW = 32;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PI_Q24 = 52707179;
  localparam int HALF_PI_Q24 = 26353589;

  class trig_scoreboard;
    logic [RW-1:0] pending_values[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function bit [63:0] mag64(longint signed a);
      return a < 0 ? 64'd0 - 64'(a) : 64'(a);
    endfunction

    // Q4.59 product, rounded to nearest with ties away from zero
    function longint signed fix_mul(longint signed a, longint signed b);
      bit neg;
      bit [127:0] p;
      bit [63:0] r;
      neg = (a < 0) != (b < 0);
      p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
      p = p + (128'd1 << (FRAC - 1));
      r = {1'b0, p[FRAC+62:FRAC]};
      return neg ? -longint'(r) : longint'(r);
    endfunction

    function longint signed sin_series(longint signed x);
      longint signed x2, p;
      x2 = fix_mul(x, x);
      p = SIN_COEF[5];
      for (int i = 4; i >= 0; i--) p = SIN_COEF[i] + fix_mul(x2, p);
      p = K_ONE + fix_mul(x2, p);
      return fix_mul(x, p);
    endfunction

    function longint signed cos_series(longint signed x);
      longint signed x2, p;
      x2 = fix_mul(x, x);
      p = COS_COEF[5];
      for (int i = 4; i >= 0; i--) p = COS_COEF[i] + fix_mul(x2, p);
      return K_ONE + fix_mul(x2, p);
    endfunction

    function logic [RW-1:0] trig_value(logic cmd, logic [AW-1:0] angle);
      bit neg;
      bit [63:0] amag, quot, rem, um;
      longint signed r, v, res;
      neg = angle[AW-1];
      amag = neg ? (64'd1 << AW) - 64'(angle) : 64'(angle);
      quot = (amag * 64'(K_INV_TWO_PI_Q16)) >> (AW - 8 + 16);
      rem = (amag << (FRAC - (AW - 8))) - quot * 64'(K_TWO_PI);
      r = longint'(rem);
      if (r > K_PI) r -= K_TWO_PI;
      if (r > K_PI) r -= K_TWO_PI;
      if (neg) r = -r;
      if (cmd == CMD_COS) begin
        r += K_HALF_PI;
        if (r > K_PI) r -= K_TWO_PI;
      end
      if (r > K_HALF_PI) r = K_PI - r;
      if (r < -K_HALF_PI) r = -K_PI - r;
      if (r > K_QUART_PI) v = cos_series(r - K_HALF_PI);
      else if (r < -K_QUART_PI) v = -cos_series(-r - K_HALF_PI);
      else v = sin_series(r);
      um = (mag64(v) + (64'd1 << (FRAC - (RW - 2) - 1))) >> (FRAC - (RW - 2));
      if (um > (64'd1 << (RW - 2))) um = 64'd1 << (RW - 2);
      res = v < 0 ? -longint'(um) : longint'(um);
      return res[RW-1:0];
    endfunction

    function void note_request(logic cmd, logic [AW-1:0] angle);
      pending_values.push_back(trig_value(cmd, angle));
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [RW-1:0] value);
      logic [RW-1:0] exp_value;
      if (pending_values.size() == 0) begin
        report($sformatf("unexpected result value=%h", value));
      end else begin
        exp_value = pending_values.pop_front();
        if (value !== exp_value)
          report($sformatf("value got %h want %h", value, exp_value));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  scp_in_if #(.ANGLE_WIDTH(AW)) in_ch ();
  scp_out_if #(.RESULT_WIDTH(RW)) out_ch ();

  sine_cosine_polynomial #(.ANGLE_WIDTH(AW), .RESULT_WIDTH(RW)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  trig_scoreboard sb = new();
  int send_idle_pct = 20;
  int recv_stall_pct = 76;
  int hold_off_req = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_SIN;
    in_ch.angle = '0;
    out_ch.ready = 1'b0;
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.cmd, in_ch.angle);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.value);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req > 0) begin
        hold = hold_off_req;
        hold_off_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task send_request(logic cmd, logic [AW-1:0] angle);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.angle <= angle;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task send_random_batch(int count);
    int kind, k;
    logic [AW-1:0] angle;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(3);
      case (kind)
        0: angle = $urandom;
        1: angle = $urandom_range(0, 1 << 27) - (1 << 26);
        2: begin
          // close to a multiple of pi/2, where the folds switch over
          k = $urandom_range(0, 160) - 80;
          angle = k * HALF_PI_Q24 + $urandom_range(0, 64) - 32;
        end
        default: angle = {$urandom_range(1) ? 8'hFF : 8'h00, 24'($urandom)};
      endcase
      send_request($urandom_range(1) ? CMD_COS : CMD_SIN, angle);
    end
  endtask

  initial begin
    logic [AW-1:0] corner_angles[11];
    corner_angles = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                      32'hFFFF_FFFF, PI_Q24, -PI_Q24, HALF_PI_Q24, -HALF_PI_Q24,
                      HALF_PI_Q24 / 2, 2 * PI_Q24};
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // corner angles with both functions, including the most negative angle
    foreach (corner_angles[i]) begin
      send_request(CMD_SIN, corner_angles[i]);
      send_request(CMD_COS, corner_angles[i]);
    end
    send_random_batch(500);

    send_idle_pct = 76;
    recv_stall_pct = 20;
    send_random_batch(500);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = 300;  // pipeline fills, input must back up
    send_random_batch(530);
    in_ch.valid <= 1'b0;

    while (sb.pending_values.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
